// ===== hw/rtl/sobel_edge_magnitude_core_macros.svh =====
// assertion macros for the sobel edge magnitude core checker
// expects clk and rst_n in the scope where a macro is used
`ifndef SOBEL_EDGE_MAGNITUDE_CORE_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_CORE_MACROS_SVH

// antecedent and consequent in the same cycle
`define SEDM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the cycle after the antecedent
`define SEDM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sedm_pkg.sv =====
// shared constants and controller/datapath interface types for the sobel core
// no dependencies
`timescale 1ns / 1ps

package sedm_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int FW_W      = 12;
    localparam int FH_W      = 13;
    localparam int OROW_W    = 12;
    localparam int CALC_W    = ((COL_W > FW_W) ? COL_W : FW_W) + 1;
    localparam int PIX_W     = 8;
    localparam int SIDE_W    = PIX_W + 2;
    localparam int SQ_W      = 2 * SIDE_W;
    localparam int SUM_W     = SQ_W + 2;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [FW_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [FH_W-1:0] HEIGHT_RESET = 13'd480;

    typedef struct packed {
        logic accept;
        logic shift;
        logic grad;
        logic square;
        logic sum;
        logic root_init;
        logic root_step;
        logic load_out;
    } sedm_cmd_t;

    typedef struct packed {
        logic drop;
        logic emit;
        logic border;
        logic root_last;
        logic out_busy;
    } sedm_status_t;

endpackage

// ===== hw/rtl/sobel_edge_magnitude_core.sv =====
// sobel_edge_magnitude_core: top level, 3x3 sobel edge magnitude over a raster pixel stream
// depends on sedm_pkg, sedm_ctrl, sedm_datapath
// input channel (in_valid/in_ready): pixel, or flush=1 to push out the tail of a frame.
// output channel (out_valid/out_ready): edge_value and frame_last on the final result.
// config: cfg_we with cfg_index 0 = frame_width, 1 = frame_height; any write restarts the
//   frame position; users must write only while no transaction is in flight (unenforced).
// results trail the input by frame_width+1 transactions; after the last pixel, flush
//   transactions (or pixels, which then count as flush) drain the rest of the frame.
// one transaction at a time through a controller and a datapath:
//   a flush dropped inside the frame ends in idle; a transaction that gives no result
//   returns from the shift state; a border pixel goes from shift to emit; an interior
//   pixel runs shift, grad, square, sum, the 8-step bit-serial square root and emit.
//   in emit the result is loaded into the output register once that register is free.
// the output register holds a result while the receiver stalls; the next transaction is
//   still accepted and runs up to the point where it needs the output register.
// reset: width 640, height 480, window cleared, frame position at zero; the line memory
//   is not cleared, its unwritten columns never reach a result.
`timescale 1ns / 1ps

module sobel_edge_magnitude_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [sedm_pkg::PIX_W-1:0]     pixel,
    input  logic                           flush,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [sedm_pkg::PIX_W-1:0]     edge_value,
    output logic                           frame_last,
    input  logic                           cfg_we,
    input  logic [sedm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sedm_pkg::CFG_W-1:0]     cfg_data
);

    sedm_pkg::sedm_cmd_t    cmd;
    sedm_pkg::sedm_status_t status;

    sedm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    sedm_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel      (pixel),
        .flush      (flush),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .status     (status),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .edge_value (edge_value),
        .frame_last (frame_last)
    );

endmodule

// ===== hw/rtl/sedm_datapath.sv =====
// sobel datapath: counters, line memory, 3x3 window, gradient, square root, output register
// depends on sedm_pkg
`timescale 1ns / 1ps

module sedm_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [sedm_pkg::PIX_W-1:0]     pixel,
    input  logic                           flush,
    input  logic                           cfg_we,
    input  logic [sedm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sedm_pkg::CFG_W-1:0]     cfg_data,
    input  sedm_pkg::sedm_cmd_t            cmd,
    output sedm_pkg::sedm_status_t         status,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [sedm_pkg::PIX_W-1:0]     edge_value,
    output logic                           frame_last
);

    // configuration, already clamped to effective values
    logic [sedm_pkg::FW_W-1:0]   width_reg;
    logic [sedm_pkg::FH_W-1:0]   height_reg;
    logic [sedm_pkg::FW_W-1:0]   width_raw;
    logic [sedm_pkg::FH_W-1:0]   height_raw;
    logic [sedm_pkg::FW_W-1:0]   width_eff;
    logic [sedm_pkg::FH_W-1:0]   height_eff;

    // position counters
    logic [sedm_pkg::COL_W-1:0]  in_col_reg;
    logic [sedm_pkg::FH_W-1:0]   in_row_reg;
    logic [sedm_pkg::COL_W-1:0]  out_col_reg;
    logic [sedm_pkg::OROW_W-1:0] out_row_reg;

    // per transaction
    logic [sedm_pkg::COL_W-1:0]  col_reg;
    logic [sedm_pkg::PIX_W-1:0]  pix_reg;
    logic                        emit_reg;
    logic                        last_reg;
    logic [2*sedm_pkg::PIX_W-1:0] rd_reg;
    logic [sedm_pkg::PIX_W-1:0]  win_reg [3][3];
    logic [2*sedm_pkg::PIX_W-1:0] line_mem [sedm_pkg::MAX_WIDTH];

    // arithmetic
    logic [sedm_pkg::SIDE_W-1:0] ax_reg;
    logic [sedm_pkg::SIDE_W-1:0] ay_reg;
    logic [sedm_pkg::SQ_W-1:0]   sqx_reg;
    logic [sedm_pkg::SQ_W-1:0]   sqy_reg;
    logic [sedm_pkg::SUM_W-1:0]  sum_reg;
    logic [sedm_pkg::PIX_W-1:0]  res_reg;
    logic [sedm_pkg::PIX_W-1:0]  bit_reg;

    // output register
    logic                        out_valid_reg;
    logic [sedm_pkg::PIX_W-1:0]  edge_reg;
    logic                        frame_last_reg;

    logic [sedm_pkg::COL_W-1:0]  col_cur;
    logic [sedm_pkg::CALC_W-1:0] col_inc;
    logic                        col_wrap;
    logic                        in_frame;
    logic                        emit_cur;
    logic [sedm_pkg::CALC_W-1:0] out_col_inc;
    logic                        row_at_end;
    logic                        col_at_end;
    logic                        last_cur;
    logic [sedm_pkg::SIDE_W-1:0] right_sum;
    logic [sedm_pkg::SIDE_W-1:0] left_sum;
    logic [sedm_pkg::SIDE_W-1:0] bottom_sum;
    logic [sedm_pkg::SIDE_W-1:0] top_sum;
    logic [sedm_pkg::PIX_W-1:0]  trial;
    logic [2*sedm_pkg::PIX_W-1:0] trial_sq;

    // clamp written sizes
    assign width_raw  = cfg_data[sedm_pkg::FW_W-1:0];
    assign height_raw = cfg_data[sedm_pkg::FH_W-1:0];

    always_comb
    begin
        if (width_raw == '0)
        begin
            width_eff = sedm_pkg::FW_W'(1);
        end
        else if (int'(width_raw) > sedm_pkg::MAX_WIDTH)
        begin
            width_eff = sedm_pkg::FW_W'(sedm_pkg::MAX_WIDTH);
        end
        else
        begin
            width_eff = width_raw;
        end
        height_eff = (height_raw == '0) ? sedm_pkg::FH_W'(1) : height_raw;
    end

    // input side position
    assign col_cur  = (sedm_pkg::CALC_W'(in_col_reg) >= sedm_pkg::CALC_W'(width_reg))
                      ? '0 : in_col_reg;
    assign col_inc  = sedm_pkg::CALC_W'(col_cur) + sedm_pkg::CALC_W'(1);
    assign col_wrap = col_inc >= sedm_pkg::CALC_W'(width_reg);
    assign in_frame = in_row_reg < height_reg;
    assign emit_cur = (in_row_reg >= sedm_pkg::FH_W'(2))
                      || ((in_row_reg == sedm_pkg::FH_W'(1)) && (col_cur != '0));

    // output side position
    assign out_col_inc = sedm_pkg::CALC_W'(out_col_reg) + sedm_pkg::CALC_W'(1);
    assign col_at_end  = out_col_inc >= sedm_pkg::CALC_W'(width_reg);
    assign row_at_end  = (sedm_pkg::FH_W'(out_row_reg) + sedm_pkg::FH_W'(1)) >= height_reg;
    assign last_cur    = row_at_end && col_at_end;

    // kernel sides from the shifted window
    assign right_sum  = sedm_pkg::SIDE_W'(win_reg[0][2]) + {1'b0, win_reg[1][2], 1'b0}
                        + sedm_pkg::SIDE_W'(win_reg[2][2]);
    assign left_sum   = sedm_pkg::SIDE_W'(win_reg[0][0]) + {1'b0, win_reg[1][0], 1'b0}
                        + sedm_pkg::SIDE_W'(win_reg[2][0]);
    assign bottom_sum = sedm_pkg::SIDE_W'(win_reg[2][0]) + {1'b0, win_reg[2][1], 1'b0}
                        + sedm_pkg::SIDE_W'(win_reg[2][2]);
    assign top_sum    = sedm_pkg::SIDE_W'(win_reg[0][0]) + {1'b0, win_reg[0][1], 1'b0}
                        + sedm_pkg::SIDE_W'(win_reg[0][2]);

    // one result bit per step, largest first
    assign trial    = res_reg | bit_reg;
    assign trial_sq = trial * trial;

    assign status.drop      = flush && in_frame;
    assign status.emit      = emit_reg;
    assign status.border    = (out_row_reg == '0) || (out_col_reg == '0) || row_at_end
                              || col_at_end;
    assign status.root_last = bit_reg[0];
    assign status.out_busy  = out_valid_reg && !out_ready;

    // configuration and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= sedm_pkg::WIDTH_RESET;
            height_reg  <= sedm_pkg::HEIGHT_RESET;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            if (cmd.accept && !status.drop)
            begin
                in_col_reg <= col_wrap ? '0 : col_inc[sedm_pkg::COL_W-1:0];
                if (col_wrap)
                begin
                    in_row_reg <= in_row_reg + sedm_pkg::FH_W'(1);
                end
            end
            if (cmd.shift && emit_reg)
            begin
                if (last_cur)
                begin
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end
                else if (col_at_end)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + sedm_pkg::OROW_W'(1);
                end
                else
                begin
                    out_col_reg <= out_col_inc[sedm_pkg::COL_W-1:0];
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    sedm_pkg::REG_FRAME_WIDTH:  width_reg  <= width_eff;
                    sedm_pkg::REG_FRAME_HEIGHT: height_reg <= height_eff;
                    default:                    width_reg  <= width_reg;
                endcase
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end
        end
    end

    // line memory: {older row, newer row} per column
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_reg <= line_mem[col_cur];
        end
        if (cmd.shift)
        begin
            line_mem[col_reg] <= {rd_reg[sedm_pkg::PIX_W-1:0], pix_reg};
        end
    end

    // window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else if (cmd.shift)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= rd_reg[2*sedm_pkg::PIX_W-1:sedm_pkg::PIX_W];
            win_reg[1][2] <= rd_reg[sedm_pkg::PIX_W-1:0];
            win_reg[2][2] <= pix_reg;
        end
    end

    // transaction payload and arithmetic
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            col_reg  <= col_cur;
            pix_reg  <= in_frame ? pixel : '0;
            emit_reg <= emit_cur;
        end
        if (cmd.shift)
        begin
            // border value is the center pixel after the shift
            res_reg  <= win_reg[1][2];
            last_reg <= last_cur;
        end
        if (cmd.grad)
        begin
            ax_reg <= (right_sum >= left_sum) ? right_sum - left_sum : left_sum - right_sum;
            ay_reg <= (bottom_sum >= top_sum) ? bottom_sum - top_sum : top_sum - bottom_sum;
        end
        if (cmd.square)
        begin
            sqx_reg <= ax_reg * ax_reg;
            sqy_reg <= ay_reg * ay_reg;
        end
        if (cmd.sum)
        begin
            sum_reg <= {sedm_pkg::SUM_W'(sqx_reg) + sedm_pkg::SUM_W'(sqy_reg)}
                       << 1;
        end
        if (cmd.root_init)
        begin
            res_reg <= '0;
            bit_reg <= {1'b1, {(sedm_pkg::PIX_W-1){1'b0}}};
        end
        if (cmd.root_step)
        begin
            if (sedm_pkg::SUM_W'(trial_sq) <= sum_reg)
            begin
                res_reg <= trial;
            end
            bit_reg <= bit_reg >> 1;
        end
        if (cmd.load_out)
        begin
            edge_reg       <= res_reg;
            frame_last_reg <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign edge_value = edge_reg;
    assign frame_last = frame_last_reg;

endmodule

// ===== hw/rtl/sedm_ctrl.sv =====
// sobel controller: sequences one transaction through the datapath
// depends on sedm_pkg
`timescale 1ns / 1ps

module sedm_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  sedm_pkg::sedm_status_t status,
    output sedm_pkg::sedm_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SHIFT  = 3'd1;
    localparam logic [2:0] S_GRAD   = 3'd2;
    localparam logic [2:0] S_SQUARE = 3'd3;
    localparam logic [2:0] S_SUM    = 3'd4;
    localparam logic [2:0] S_ROOT   = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                // a flush inside the frame is swallowed here
                if (accept && !status.drop)
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (!status.emit)
                begin
                    state_next = S_IDLE;
                end
                else if (status.border)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_GRAD;
                end
            end
            S_GRAD:   state_next = S_SQUARE;
            S_SQUARE: state_next = S_SUM;
            S_SUM:    state_next = S_ROOT;
            S_ROOT:
            begin
                if (status.root_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!status.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd.accept    = accept;
    assign cmd.shift     = (state_reg == S_SHIFT);
    assign cmd.grad      = (state_reg == S_GRAD);
    assign cmd.square    = (state_reg == S_SQUARE);
    assign cmd.sum       = (state_reg == S_SUM);
    assign cmd.root_init = (state_reg == S_SUM);
    assign cmd.root_step = (state_reg == S_ROOT);
    assign cmd.load_out  = (state_reg == S_EMIT) && !status.out_busy;

endmodule

// ===== hw/rtl/sedm_checker.sv =====
// port-level checker for sobel_edge_magnitude_core, bound to the top level
// depends on sobel_edge_magnitude_core_macros.svh and sedm_pkg
`timescale 1ns / 1ps
`include "sobel_edge_magnitude_core_macros.svh"

module sedm_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       flush,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [sedm_pkg::PIX_W-1:0] edge_value,
    input logic                       frame_last
);

    // a stalled result stays presented
    `SEDM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

    `SEDM_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(edge_value) && $stable(frame_last), "result changed while stalled")

    // after a pixel is accepted, ready goes low while the controller moves on to the shift state
    `SEDM_ASSERT_NEXT(a_busy_after_pixel, in_valid && in_ready && !flush, !in_ready, "ready stayed high after a pixel")

    // a new result is only loaded while no input is being taken
    `SEDM_ASSERT_SAME(a_load_while_busy, $rose(out_valid), !$past(in_ready), "result appeared while idle")

endmodule

bind sobel_edge_magnitude_core sedm_checker u_sedm_checker (.*);
